// File: sv/bbb_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the box boundary bounce block
package bbb_pkg;

	// number of spatial axes handled per transaction
	localparam int NUM_AXES = 3;

	// configuration register index, from paddr[4:2]
	typedef enum logic [2:0] {
		REG_MIN_X       = 3'd0,
		REG_MIN_Y       = 3'd1,
		REG_MIN_Z       = 3'd2,
		REG_MAX_X       = 3'd3,
		REG_MAX_Y       = 3'd4,
		REG_MAX_Z       = 3'd5,
		REG_BOUNCE_GAIN = 3'd6,
		REG_DRAG_SHARE  = 3'd7
	} reg_idx_t;

	// apb address and data widths
	localparam int ADDR_WIDTH = 5;
	localparam int DATA_WIDTH = 32;

endpackage

// File: sv/bbb_regs.sv
`timescale 1ns / 1ps
// apb configuration registers: box bounds, restitution and drag
module bbb_regs import bbb_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_WIDTH-1:0]         paddr,
	input  logic [DATA_WIDTH-1:0]         pwdata,
	output logic [DATA_WIDTH-1:0]         prdata,
	output logic                          pready,
	output logic signed [COORD_WIDTH-1:0] lo [NUM_AXES],
	output logic signed [COORD_WIDTH-1:0] hi [NUM_AXES],
	output logic [FRAC_BITS:0]            bounce_gain,
	output logic [FRAC_BITS:0]            drag_share
);

	localparam int UNITY = 1 << FRAC_BITS;
	localparam logic signed [COORD_WIDTH-1:0] LO_RST = COORD_WIDTH'(-(5 << FRAC_BITS));
	localparam logic signed [COORD_WIDTH-1:0] HI_RST = COORD_WIDTH'(5 << FRAC_BITS);
	localparam logic [FRAC_BITS:0] BOUNCE_RST = (FRAC_BITS+1)'(UNITY / 2);
	localparam logic [FRAC_BITS:0] DRAG_RST   = (FRAC_BITS+1)'((UNITY + 5) / 10);

	logic signed [COORD_WIDTH-1:0] lo_q [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] hi_q [NUM_AXES];
	logic [FRAC_BITS:0]            bounce_q;
	logic [FRAC_BITS:0]            drag_q;
	logic                          wr_en;
	reg_idx_t                      idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				lo_q[i] <= LO_RST;
				hi_q[i] <= HI_RST;
			end
			bounce_q <= BOUNCE_RST;
			drag_q   <= DRAG_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MIN_X:       lo_q[0]  <= pwdata[COORD_WIDTH-1:0];
				REG_MIN_Y:       lo_q[1]  <= pwdata[COORD_WIDTH-1:0];
				REG_MIN_Z:       lo_q[2]  <= pwdata[COORD_WIDTH-1:0];
				REG_MAX_X:       hi_q[0]  <= pwdata[COORD_WIDTH-1:0];
				REG_MAX_Y:       hi_q[1]  <= pwdata[COORD_WIDTH-1:0];
				REG_MAX_Z:       hi_q[2]  <= pwdata[COORD_WIDTH-1:0];
				REG_BOUNCE_GAIN: bounce_q <= pwdata[FRAC_BITS:0];
				REG_DRAG_SHARE:  drag_q   <= pwdata[FRAC_BITS:0];
				default: ;
			endcase
		end
	end

	// read mux, bounds sign extended
	always_comb begin
		unique case (idx)
			REG_MIN_X:       prdata = DATA_WIDTH'(lo_q[0]);
			REG_MIN_Y:       prdata = DATA_WIDTH'(lo_q[1]);
			REG_MIN_Z:       prdata = DATA_WIDTH'(lo_q[2]);
			REG_MAX_X:       prdata = DATA_WIDTH'(hi_q[0]);
			REG_MAX_Y:       prdata = DATA_WIDTH'(hi_q[1]);
			REG_MAX_Z:       prdata = DATA_WIDTH'(hi_q[2]);
			REG_BOUNCE_GAIN: prdata = DATA_WIDTH'(bounce_q);
			REG_DRAG_SHARE:  prdata = DATA_WIDTH'(drag_q);
			default:         prdata = '0;
		endcase
	end

	assign lo          = lo_q;
	assign hi          = hi_q;
	assign bounce_gain = bounce_q;
	assign drag_share  = drag_q;

endmodule

// File: sv/bbb_axis_clamp.sv
`timescale 1ns / 1ps
// one axis: clamp position to the box, flag an outward velocity and negate it
module bbb_axis_clamp #(
	parameter int COORD_WIDTH = 16
) (
	input  logic signed [COORD_WIDTH-1:0] pos,
	input  logic signed [COORD_WIDTH-1:0] vel,
	input  logic signed [COORD_WIDTH-1:0] lo,
	input  logic signed [COORD_WIDTH-1:0] hi,
	output logic signed [COORD_WIDTH-1:0] pos_o,
	output logic signed [COORD_WIDTH-1:0] vel_o,
	output logic                          hit
);

	localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic signed [COORD_WIDTH-1:0] neg_v;

	// negation with the most negative value saturating
	assign neg_v = (vel == MINV) ? MAXV : -vel;

	// minimum test first, so in an inverted box a position below the minimum clamps to it
	always_comb begin
		pos_o = pos;
		hit   = 1'b0;
		if (pos < lo) begin
			pos_o = lo;
			hit   = vel[COORD_WIDTH-1];
		end else if (pos > hi) begin
			pos_o = hi;
			hit   = (vel > 0);
		end
		vel_o = hit ? neg_v : vel;
	end

endmodule

// File: sv/bbb_gain_mul.sv
`timescale 1ns / 1ps
// optional scale of a signed coordinate by an unsigned gain, floor shift
module bbb_gain_mul #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                          en,
	input  logic signed [COORD_WIDTH-1:0] val,
	input  logic [FRAC_BITS:0]            gain,
	output logic signed [COORD_WIDTH-1:0] res
);

	localparam int PW = COORD_WIDTH + FRAC_BITS + 2;
	localparam logic [FRAC_BITS:0] UNITY = (FRAC_BITS+1)'(1 << FRAC_BITS);

	logic [FRAC_BITS:0]   gain_c;
	logic signed [PW-1:0] prod;

	// gains above one are held at one
	assign gain_c = (gain > UNITY) ? UNITY : gain;
	assign prod   = PW'(val) * $signed(PW'(gain_c));
	assign res    = en ? prod[FRAC_BITS +: COORD_WIDTH] : val;

endmodule

// File: sv/box_boundary_bounce.sv
`timescale 1ns / 1ps
// box boundary bounce top level: three stage particle pipeline and apb registers
//
// Input channel (in_valid/in_ready) carries one particle: position and velocity
// on x, y, z, signed fixed point. Output channel (out_valid/out_ready) returns
// the clamped position, the updated velocity and a bounced flag, one result
// per transaction, in order.
// Stage 1 clamps each axis and negates outward velocities, stage 2 applies
// the restitution multiply, stage 3 applies the drag multiply and is the
// output register, whose valid bit is out_valid.
// Throughput is one transaction per cycle while out_ready stays high; each
// stage holds one multiplier per axis at most, which sets the clock period.
// Each stage moves forward when it is empty or the next one moves, so a
// stalled receiver holds its result while bubbles still fill; in_ready drops
// only when all three stages are full and out_ready is low.
// Reset empties the pipeline and loads the box to -5.0..5.0 on each axis,
// restitution 0.5 and drag about 0.1. Configuration writes belong to idle periods.
module box_boundary_bounce import bbb_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_WIDTH-1:0]         paddr,
	input  logic [DATA_WIDTH-1:0]         pwdata,
	output logic [DATA_WIDTH-1:0]         prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic signed [COORD_WIDTH-1:0] vel_x,
	input  logic signed [COORD_WIDTH-1:0] vel_y,
	input  logic signed [COORD_WIDTH-1:0] vel_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] new_pos_x,
	output logic signed [COORD_WIDTH-1:0] new_pos_y,
	output logic signed [COORD_WIDTH-1:0] new_pos_z,
	output logic signed [COORD_WIDTH-1:0] new_vel_x,
	output logic signed [COORD_WIDTH-1:0] new_vel_y,
	output logic signed [COORD_WIDTH-1:0] new_vel_z,
	output logic                          bounced
);

	localparam logic [FRAC_BITS:0] UNITY = (FRAC_BITS+1)'(1 << FRAC_BITS);

	logic signed [COORD_WIDTH-1:0] lo [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] hi [NUM_AXES];
	logic [FRAC_BITS:0]            bounce_gain;
	logic [FRAC_BITS:0]            drag_share;
	logic [FRAC_BITS:0]            drag_c;
	logic [FRAC_BITS:0]            keep;
	logic                          drag_on;

	logic signed [COORD_WIDTH-1:0] pos_in [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] vel_in [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] pos_c  [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] vel_c  [NUM_AXES];
	logic [NUM_AXES-1:0]           hit_c;
	logic signed [COORD_WIDTH-1:0] vel_b  [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] vel_d  [NUM_AXES];

	logic                          v_s1, v_s2, v_s3;
	logic                          adv1, adv2, adv3;
	logic signed [COORD_WIDTH-1:0] pos_s1 [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] vel_s1 [NUM_AXES];
	logic [NUM_AXES-1:0]           hit_s1;
	logic signed [COORD_WIDTH-1:0] pos_s2 [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] vel_s2 [NUM_AXES];
	logic                          any_s2;
	logic signed [COORD_WIDTH-1:0] pos_s3 [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] vel_s3 [NUM_AXES];
	logic                          any_s3;

	// configuration registers
	bbb_regs #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.lo         (lo),
		.hi         (hi),
		.bounce_gain(bounce_gain),
		.drag_share (drag_share)
	);

	// stage advance: a stage moves when empty or when the next one moves
	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	assign pos_in = '{pos_x, pos_y, pos_z};
	assign vel_in = '{vel_x, vel_y, vel_z};

	// drag factor, one minus the held share
	assign drag_c  = (drag_share > UNITY) ? UNITY : drag_share;
	assign keep    = UNITY - drag_c;
	assign drag_on = any_s2 && (drag_share != '0);

	// per axis datapath
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		bbb_axis_clamp #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_clamp (
			.pos  (pos_in[a]),
			.vel  (vel_in[a]),
			.lo   (lo[a]),
			.hi   (hi[a]),
			.pos_o(pos_c[a]),
			.vel_o(vel_c[a]),
			.hit  (hit_c[a])
		);

		bbb_gain_mul #(
			.COORD_WIDTH(COORD_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_bounce (
			.en  (hit_s1[a]),
			.val (vel_s1[a]),
			.gain(bounce_gain),
			.res (vel_b[a])
		);

		bbb_gain_mul #(
			.COORD_WIDTH(COORD_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_drag (
			.en  (drag_on),
			.val (vel_s2[a]),
			.gain(keep),
			.res (vel_d[a])
		);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv1) begin
			pos_s1 <= pos_c;
			vel_s1 <= vel_c;
			hit_s1 <= hit_c;
		end
		if (adv2) begin
			pos_s2 <= pos_s1;
			vel_s2 <= vel_b;
			any_s2 <= |hit_s1;
		end
		if (adv3) begin
			pos_s3 <= pos_s2;
			vel_s3 <= vel_d;
			any_s3 <= any_s2;
		end
	end

	assign out_valid = v_s3;
	assign new_pos_x = pos_s3[0];
	assign new_pos_y = pos_s3[1];
	assign new_pos_z = pos_s3[2];
	assign new_vel_x = vel_s3[0];
	assign new_vel_y = vel_s3[1];
	assign new_vel_z = vel_s3[2];
	assign bounced   = any_s3;

`ifndef NO_ASSERTIONS
	// an occupied middle stage is never dropped while the output stalls
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv3 |=> v_s2)
		else $error("stage 2 lost a transaction under stall");

	// an empty first stage always takes a new transaction
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

	// an x axis without a bounce passes its velocity through the restitution stage
	a_no_hit_pass: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv2 && !hit_s1[0] |=> vel_s2[0] == $past(vel_s1[0]))
		else $error("velocity changed on an axis that did not bounce");

	// with an ordered box the delivered x position lies inside it
	a_pos_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (lo[0] <= hi[0]) |-> (new_pos_x >= lo[0]) && (new_pos_x <= hi[0]))
		else $error("clamped position outside the box");
`endif

endmodule

// File: bench/box_boundary_bounce_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the box boundary bounce block: apb setup, random particle streams
module box_boundary_bounce_tb import bbb_pkg::*; ();

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PIPE_LATENCY = 3;
	localparam int PHASE_ITEMS  = 66;

	// one particle as it enters the block
	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_z;
	} particle_t;

	// one confined particle as it leaves the block
	typedef struct packed {
		logic signed [15:0] new_pos_x;
		logic signed [15:0] new_pos_y;
		logic signed [15:0] new_pos_z;
		logic signed [15:0] new_vel_x;
		logic signed [15:0] new_vel_y;
		logic signed [15:0] new_vel_z;
		logic               bounced;
	} outcome_t;

	// receiver behavior, picked anew at random each time rx_left runs out
	typedef enum logic [1:0] {
		RX_STREAM,
		RX_RANDOM,
		RX_PERIODIC,
		RX_CHOKED
	} rx_mode_t;

	// mirror of the box registers plus the queue of predicted outcomes
	class bounce_scoreboard;
		localparam int FRAC_BITS = 8;
		localparam int UNITY     = 1 << FRAC_BITS;
		localparam int COORD_MIN = -32768;
		localparam int COORD_MAX = 32767;

		int       box_lo [3];
		int       box_hi [3];
		int       bounce_gain;
		int       drag_share;
		outcome_t queued_outcomes [$];
		int       fail_count;
		int       outcome_index;

		function new();
			// register values after reset: box -5.0..5.0, gain 0.5, drag about 0.1
			foreach (box_lo[a]) begin
				box_lo[a] = -1280;
				box_hi[a] = 1280;
			end
			bounce_gain   = 128;
			drag_share    = 26;
			fail_count    = 0;
			outcome_index = 0;
		endfunction

		task report_mismatch(input string what);
			if (fail_count < 100)
				$display("[%0t] mismatch: %s", $time, what);
			fail_count++;
		endtask

		// track a register write, keeping only the bits the block keeps
		function void set_reg(input reg_idx_t idx, input logic [31:0] data);
			case (idx)
				REG_MIN_X:       box_lo[0] = $signed(data[15:0]);
				REG_MIN_Y:       box_lo[1] = $signed(data[15:0]);
				REG_MIN_Z:       box_lo[2] = $signed(data[15:0]);
				REG_MAX_X:       box_hi[0] = $signed(data[15:0]);
				REG_MAX_Y:       box_hi[1] = $signed(data[15:0]);
				REG_MAX_Z:       box_hi[2] = $signed(data[15:0]);
				REG_BOUNCE_GAIN: bounce_gain = data[8:0];
				REG_DRAG_SHARE:  drag_share = data[8:0];
				default: ;
			endcase
		endfunction

		// clamp one axis, reflect an outward velocity scaled by restitution
		function bit reflect_axis(inout int p, inout int v, input int lo, input int hi);
			bit hit;
			int flipped;
			int gain;
			hit  = 1'b0;
			gain = (bounce_gain > UNITY) ? UNITY : bounce_gain;
			// minimum test wins, so an inverted box clamps low first
			if (p < lo) begin
				p   = lo;
				hit = (v < 0);
			end else if (p > hi) begin
				p   = hi;
				hit = (v > 0);
			end
			if (hit) begin
				// negating the most negative value saturates
				flipped = (v == COORD_MIN) ? COORD_MAX : -v;
				v = (flipped * gain) >>> FRAC_BITS;
			end
			return hit;
		endfunction

		function outcome_t reflect_particle(input particle_t pt);
			int       p [3];
			int       v [3];
			bit       any;
			int       keep;
			outcome_t res;
			p[0] = pt.pos_x;
			p[1] = pt.pos_y;
			p[2] = pt.pos_z;
			v[0] = pt.vel_x;
			v[1] = pt.vel_y;
			v[2] = pt.vel_z;
			any = 1'b0;
			for (int a = 0; a < 3; a++)
				any = reflect_axis(p[a], v[a], box_lo[a], box_hi[a]) | any;
			// friction after any bounce scales all three components
			if (any && drag_share != 0) begin
				keep = UNITY - ((drag_share > UNITY) ? UNITY : drag_share);
				for (int a = 0; a < 3; a++)
					v[a] = (v[a] * keep) >>> FRAC_BITS;
			end
			res.new_pos_x = 16'(p[0]);
			res.new_pos_y = 16'(p[1]);
			res.new_pos_z = 16'(p[2]);
			res.new_vel_x = 16'(v[0]);
			res.new_vel_y = 16'(v[1]);
			res.new_vel_z = 16'(v[2]);
			res.bounced   = any;
			return res;
		endfunction

		function void note_particle(input particle_t pt);
			queued_outcomes.insert(queued_outcomes.size(), reflect_particle(pt));
		endfunction

		task check_field(input string name, input int got, input int want);
			if (got != want)
				report_mismatch($sformatf("transaction %0d %s got %0d expected %0d",
					outcome_index, name, got, want));
		endtask

		task check_result(input outcome_t got);
			outcome_t want;
			if (queued_outcomes.size() == 0) begin
				report_mismatch($sformatf("transaction %0d arrived with nothing pending",
					outcome_index));
			end else begin
				want = queued_outcomes.pop_front();
				check_field("new_pos_x", got.new_pos_x, want.new_pos_x);
				check_field("new_pos_y", got.new_pos_y, want.new_pos_y);
				check_field("new_pos_z", got.new_pos_z, want.new_pos_z);
				check_field("new_vel_x", got.new_vel_x, want.new_vel_x);
				check_field("new_vel_y", got.new_vel_y, want.new_vel_y);
				check_field("new_vel_z", got.new_vel_z, want.new_vel_z);
				check_field("bounced", got.bounced, want.bounced);
			end
			outcome_index++;
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr     = '0;
	logic [DATA_WIDTH-1:0] pwdata    = '0;
	logic [DATA_WIDTH-1:0] prdata;
	logic                  pready;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic signed [15:0]    pos_x     = '0;
	logic signed [15:0]    pos_y     = '0;
	logic signed [15:0]    pos_z     = '0;
	logic signed [15:0]    vel_x     = '0;
	logic signed [15:0]    vel_y     = '0;
	logic signed [15:0]    vel_z     = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [15:0]    new_pos_x;
	logic signed [15:0]    new_pos_y;
	logic signed [15:0]    new_pos_z;
	logic signed [15:0]    new_vel_x;
	logic signed [15:0]    new_vel_y;
	logic signed [15:0]    new_vel_z;
	logic                  bounced;

	rx_mode_t         rx_mode     = RX_STREAM;
	int               rx_left     = 0;
	int               rx_tick     = 0;
	int               cycle_count = 0;
	bounce_scoreboard sb;

	box_boundary_bounce i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_z     (vel_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.new_pos_x (new_pos_x),
		.new_pos_y (new_pos_y),
		.new_pos_z (new_pos_z),
		.new_vel_x (new_vel_x),
		.new_vel_y (new_vel_y),
		.new_vel_z (new_vel_z),
		.bounced   (bounced)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("box_boundary_bounce regression: fail");
			$finish;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_STREAM:   out_ready <= 1'b1;
			RX_RANDOM:   out_ready <= 1'($urandom);
			RX_PERIODIC: out_ready <= (rx_tick % 5) < 3;
			default:     out_ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// output transaction monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(outcome_t'{new_pos_x, new_pos_y, new_pos_z,
				new_vel_x, new_vel_y, new_vel_z, bounced});
	end

	function automatic particle_t make_particle(input int px, input int py, input int pz,
		input int vx, input int vy, input int vz);
		particle_t pt;
		pt.pos_x = 16'(px);
		pt.pos_y = 16'(py);
		pt.pos_z = 16'(pz);
		pt.vel_x = 16'(vx);
		pt.vel_y = 16'(vy);
		pt.vel_z = 16'(vz);
		return pt;
	endfunction

	function automatic int saturate_coord(input int c);
		if (c < bounce_scoreboard::COORD_MIN)
			return bounce_scoreboard::COORD_MIN;
		if (c > bounce_scoreboard::COORD_MAX)
			return bounce_scoreboard::COORD_MAX;
		return c;
	endfunction

	// positions aimed mostly at and around the box faces
	function automatic int random_coord(input int lo, input int hi);
		int c;
		case ($urandom_range(0, 9))
			0:       c = bounce_scoreboard::COORD_MIN;
			1:       c = bounce_scoreboard::COORD_MAX;
			2:       c = $signed(16'($urandom));
			3, 4:    c = lo - int'($urandom_range(0, 600));
			5, 6:    c = hi + int'($urandom_range(0, 600));
			7:       c = $urandom_range(0, 1) ? lo : hi;
			default: c = ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 1200)) - 600;
		endcase
		return saturate_coord(c);
	endfunction

	function automatic int random_speed();
		case ($urandom_range(0, 9))
			0:             return bounce_scoreboard::COORD_MIN;
			1:             return bounce_scoreboard::COORD_MAX;
			2, 3, 4, 5:    return $signed(16'($urandom));
			default:       return int'($urandom_range(0, 2048)) - 1024;
		endcase
	endfunction

	function automatic particle_t random_particle();
		return make_particle(random_coord(sb.box_lo[0], sb.box_hi[0]),
			random_coord(sb.box_lo[1], sb.box_hi[1]),
			random_coord(sb.box_lo[2], sb.box_hi[2]),
			random_speed(), random_speed(), random_speed());
	endfunction

	// one apb write: setup then access; the caller releases psel afterwards
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
	endtask

	// write all eight registers, junk in the unused upper bits
	task automatic configure_box(input int lo [3], input int hi [3], input int gain,
		input int drag);
		reg_idx_t lo_reg [3];
		reg_idx_t hi_reg [3];
		lo_reg = '{REG_MIN_X, REG_MIN_Y, REG_MIN_Z};
		hi_reg = '{REG_MAX_X, REG_MAX_Y, REG_MAX_Z};
		for (int a = 0; a < 3; a++) begin
			write_reg(lo_reg[a], {16'($urandom), 16'(lo[a])});
			write_reg(hi_reg[a], {16'($urandom), 16'(hi[a])});
		end
		write_reg(REG_BOUNCE_GAIN, {23'($urandom), 9'(gain)});
		write_reg(REG_DRAG_SHARE, {23'($urandom), 9'(drag)});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// present one particle and hold it until the block takes it
	task automatic send_particle(input particle_t pt);
		in_valid <= 1'b1;
		pos_x    <= pt.pos_x;
		pos_y    <= pt.pos_y;
		pos_z    <= pt.pos_z;
		vel_x    <= pt.vel_x;
		vel_y    <= pt.vel_y;
		vel_z    <= pt.vel_z;
		do @(posedge clk); while (!in_ready);
		sb.note_particle(pt);
		@(negedge clk);
	endtask

	// random particles in bursts with random gaps
	task automatic stream_particles(input int count);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(0, 4) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 12);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_particle(random_particle());
				sent++;
			end
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// stop sending and wait for the pipeline to empty
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (sb.queued_outcomes.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic int random_bound();
		return $urandom_range(0, 1) ? $signed(16'($urandom)) : int'($urandom_range(0, 4000)) - 2000;
	endfunction

	initial begin
		int lo [3];
		int hi [3];
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset box: corner cases of clamping and reflection
		send_particle(make_particle(0, 0, 0, 0, 0, 0));
		send_particle(make_particle(-2000, 2000, 0, -300, 300, 50));
		send_particle(make_particle(-2000, 2000, -1280, 300, -300, -100));
		send_particle(make_particle(-32768, -32768, -32768, -32768, -32768, -32768));
		send_particle(make_particle(32767, 32767, 32767, 32767, 32767, 32767));
		send_particle(make_particle(32767, -32768, 1280, -32768, 32767, 32767));
		send_particle(make_particle(0, 0, 1281, -32768, 32767, 1));
		send_particle(make_particle(-1281, 0, 0, -1, 0, 0));
		send_particle(make_particle(21845, 21845, 21845, -21846, -21846, -21846));
		send_particle(make_particle(-21846, -21846, -21846, 21845, 21845, 21845));
		stream_particles(PHASE_ITEMS);
		drain_pipeline();

		// asymmetric box, unity restitution, no drag
		configure_box('{-1000, -500, -2000}, '{1000, 3000, 2000}, 256, 0);
		stream_particles(PHASE_ITEMS);
		drain_pipeline();

		// widest box on x, zero-size box on y and z, full drag
		configure_box('{-32768, 0, 0}, '{32767, 0, 0}, 0, 256);
		stream_particles(PHASE_ITEMS);
		drain_pipeline();

		// inverted box, gains above unity
		configure_box('{500, 500, 500}, '{-500, -500, -500}, 511, 511);
		send_particle(make_particle(0, 1000, -1000, -40, 40, 40));
		send_particle(make_particle(1000, 0, 600, 77, -77, 77));
		send_particle(make_particle(-32768, -32768, -32768, -32768, -32768, -32768));
		stream_particles(PHASE_ITEMS);
		drain_pipeline();

		// box pinned at the coordinate extremes
		configure_box('{32767, -32768, -32768}, '{32767, -32768, 32767}, 255, 1);
		stream_particles(PHASE_ITEMS);
		drain_pipeline();

		// random boxes and gains
		for (int ph = 0; ph < 3; ph++) begin
			for (int a = 0; a < 3; a++) begin
				lo[a] = random_bound();
				hi[a] = $urandom_range(0, 3) == 0 ? random_bound() : saturate_coord(lo[a] +
					int'($urandom_range(0, 3000)));
			end
			configure_box(lo, hi, $urandom_range(0, 511), $urandom_range(0, 511));
			stream_particles(PHASE_ITEMS);
			drain_pipeline();
		end

		if (sb.queued_outcomes.size() != 0)
			sb.report_mismatch($sformatf("%0d transactions never came out",
				sb.queued_outcomes.size()));
		if (sb.fail_count == 0)
			$display("box_boundary_bounce regression: pass");
		else
			$display("box_boundary_bounce regression: fail");
		$finish;
	end

endmodule
